// ===== rtl/ucds_pkg.sv =====
// Shared types and constants for the UART clock divisor search unit.
`timescale 1ns / 1ps

package ucds_pkg;

    localparam int MAX_DIVISOR = 128;
    // Wide enough to hold MAX_DIVISOR + 1, the value that ends the sweep
    localparam int DIV_W       = $clog2(MAX_DIVISOR + 2);
    localparam int DIV_HALF    = MAX_DIVISOR / 2;

    localparam int RATE_W  = 22;
    localparam int HZ_W    = 30;
    localparam int QW      = 32;
    localparam int CNT_W   = $clog2(QW);
    localparam int BGEN_W  = 26;

    localparam logic [HZ_W-1:0] PLL_RESET = 30'd266333333;
    localparam logic [HZ_W-1:0] OPB_RESET = 30'd66600000;

    localparam logic       CFG_PLL_HZ = 1'b0;
    localparam logic       CFG_OPB_HZ = 1'b1;

    localparam logic [6:0] FIELD_MASK = 7'h7F;
    localparam logic [7:0] STOP_CODE  = 8'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_INIT_WAIT,
        ST_CHECK,
        ST_SC_WAIT,
        ST_B_START,
        ST_B_WAIT,
        ST_B_CHECK,
        ST_A_WAIT,
        ST_UPDATE,
        ST_FREQ_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        DSEL_START,
        DSEL_SC,
        DSEL_B,
        DSEL_A,
        DSEL_FREQ
    } div_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_start;
        logic     cap_sc;
        logic     cap_b;
        logic     cap_a;
        logic     update;
        logic     step_d;
        logic     cap_freq;
        logic     push;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic no_search;
        logic d_over;
        logic b_zero;
        logic found;
        logic res_free;
    } sts_t;

    typedef struct packed {
        logic            found;
        logic [7:0]      divisor;
        logic [HZ_W-1:0] freq;
        logic [15:0]     fval;
        logic [14:0]     fmask;
    } res_t;

endpackage

// ===== rtl/uart_clock_divisor_search_unit.sv =====
// Top level of the UART clock divisor search unit: stream ports and result register.
`timescale 1ns / 1ps

// One request at a time. For each requested baud rate the unit sweeps serial
// clock divisors d from 2*ceil(pll_hz/opb_hz) up to MAX_DIVISOR (128) and keeps
// the one with the least baud error, then divides pll_hz by it. All division
// goes through one shared 32-bit restoring divider. A trial divides for the
// serial clock, the generator value and the actual rate, and skips the last
// division when the generator value comes out zero; a request makes at most
// 127 trials, none when the rate or a clock register is zero or when the start
// lies above 128. Stalls on the master side hold the unit only while the
// result register is still full. The result sits in an output register, so
// a new request is taken while the previous result waits on the master side.
// pll_hz and opb_hz are written through cfg_we/cfg_index/cfg_data (index 0
// and 1); the user must write them only while the unit is idle, since the
// block itself does not enforce it.
module uart_clock_divisor_search_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [ucds_pkg::HZ_W-1:0] cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // baud_rate[21:0], zero fill
    input  logic                      s_tuser,   // uart_select
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [71:0]               m_tdata,   // best_divisor[7:0], serial_freq[37:8],
                                                 // field_value[53:38], field_mask[68:54]
    output logic                      m_tuser    // divisor_found
);
    import ucds_pkg::*;

    cmd_t cmd;
    sts_t sts;
    res_t res;

    logic m_tvalid_reg;
    res_t res_reg;
    logic res_free;

    assign res_free = !m_tvalid_reg || m_tready;

    ucds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ucds_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .baud_rate   (s_tdata[RATE_W-1:0]),
        .uart_select (s_tuser),
        .cmd         (cmd),
        .res_free    (res_free),
        .sts         (sts),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.push)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            res_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_reg.found;
    assign m_tdata  = {3'd0, res_reg.fmask, res_reg.fval, res_reg.freq, res_reg.divisor};

endmodule

// ===== rtl/ucds_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ucds_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ucds_pkg::QW-1:0] num,
    input  logic [ucds_pkg::QW-1:0] den,
    output logic                 done,
    output logic [ucds_pkg::QW-1:0] quotient
);
    import ucds_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [QW-1:0]    den_reg, den_next;
    logic [QW:0]      trial;
    logic [QW:0]      diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[QW-1]};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (!diff[QW])
            begin
                rem_next = diff[QW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[QW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/ucds_datapath.sv =====
// Datapath: clock registers, operand selection, divider and best-divisor tracking.
`timescale 1ns / 1ps

module ucds_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [ucds_pkg::HZ_W-1:0]   cfg_data,
    input  logic [ucds_pkg::RATE_W-1:0] baud_rate,
    input  logic                        uart_select,
    input  ucds_pkg::cmd_t              cmd,
    input  logic                        res_free,
    output ucds_pkg::sts_t              sts,
    output ucds_pkg::res_t              res
);
    import ucds_pkg::*;

    logic [HZ_W-1:0]   pll_reg;
    logic [HZ_W-1:0]   opb_reg;
    logic [RATE_W-1:0] rate_reg;
    logic              sel_reg;
    logic [DIV_W-1:0]  d_reg;
    logic [HZ_W-1:0]   sc_reg;
    logic [BGEN_W-1:0] b_reg;
    logic [HZ_W-1:0]   a_reg;
    logic [DIV_W-1:0]  best_d_reg;
    logic [HZ_W-1:0]   best_e_reg;
    logic              found_reg;
    logic [HZ_W-1:0]   freq_reg;

    logic [QW-1:0]     div_num;
    logic [QW-1:0]     div_den;
    logic              div_done;
    logic [QW-1:0]     quotient;
    logic [HZ_W-1:0]   rate_ext;
    logic [HZ_W-1:0]   err;
    logic              better;
    logic [QW-1:0]     best_ext;
    logic [7:0]        best8;
    logic [7:0]        base;

    ucds_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_START:
            begin
                div_num = QW'(pll_reg) + QW'(opb_reg) - 1'b1;
                div_den = QW'(opb_reg);
            end
            DSEL_SC:
            begin
                div_num = QW'(pll_reg) << 1;
                div_den = QW'(d_reg);
            end
            DSEL_B:
            begin
                div_num = QW'(sc_reg) + (QW'(rate_reg) << 3) - 1'b1;
                div_den = QW'(rate_reg) << 4;
            end
            DSEL_A:
            begin
                div_num = QW'(sc_reg) + (QW'(b_reg) << 3) - 1'b1;
                div_den = QW'(b_reg) << 4;
            end
            DSEL_FREQ:
            begin
                div_num = QW'(pll_reg);
                div_den = QW'(best_d_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '1;
            end
        endcase
    end

    // Error against the rate and the replacement rule; an even d beats an odd best on a tie
    always_comb
    begin
        rate_ext = HZ_W'(rate_reg);
        err      = (rate_ext >= a_reg) ? (rate_ext - a_reg) : (a_reg - rate_ext);
        better   = !found_reg || (err < best_e_reg) ||
                   ((err == best_e_reg) && best_d_reg[0] && !d_reg[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pll_reg <= PLL_RESET;
            opb_reg <= OPB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PLL_HZ: pll_reg <= cfg_data;
                CFG_OPB_HZ: opb_reg <= cfg_data;
                default:    pll_reg <= pll_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.load_item)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.update && better)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            rate_reg <= baud_rate;
            sel_reg  <= uart_select;
            freq_reg <= '0;
        end
        if (cmd.cap_start)
        begin
            if (quotient > QW'(DIV_HALF))
                d_reg <= DIV_W'(MAX_DIVISOR + 1);
            else
                d_reg <= {quotient[DIV_W-2:0], 1'b0};
        end
        else if (cmd.step_d)
        begin
            d_reg <= d_reg + 1'b1;
        end
        if (cmd.cap_sc)
            sc_reg <= quotient[HZ_W-1:0];
        if (cmd.cap_b)
            b_reg <= quotient[BGEN_W:1];
        if (cmd.cap_a)
            a_reg <= quotient[HZ_W:1];
        if (cmd.update && better)
        begin
            best_d_reg <= d_reg;
            best_e_reg <= err;
        end
        if (cmd.cap_freq)
            freq_reg <= quotient[HZ_W-1:0];
    end

    always_comb
    begin
        sts.div_done  = div_done;
        sts.no_search = (rate_reg == '0) || (pll_reg == '0) || (opb_reg == '0);
        sts.d_over    = d_reg > DIV_W'(MAX_DIVISOR);
        sts.b_zero    = (b_reg == '0);
        sts.found     = found_reg;
        sts.res_free  = res_free;
    end

    always_comb
    begin
        best_ext    = QW'(best_d_reg);
        best8       = found_reg ? best_ext[7:0] : 8'd0;
        base        = found_reg ? best_ext[7:0] : STOP_CODE;
        res.found   = found_reg;
        res.divisor = best8;
        res.freq    = freq_reg;
        res.fval    = sel_reg ? {base, 8'd0} : {8'd0, base};
        res.fmask   = sel_reg ? {FIELD_MASK, 8'd0} : {8'd0, FIELD_MASK};
    end

endmodule

// ===== rtl/ucds_ctrl.sv =====
// Controller: sequences the start division, the divisor sweep and the final frequency.
`timescale 1ns / 1ps

module ucds_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ucds_pkg::sts_t sts,
    output ucds_pkg::cmd_t cmd
);
    import ucds_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = DSEL_START;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (sts.no_search)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_START;
                    state_next    = ST_INIT_WAIT;
                end
            end
            ST_INIT_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_start = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.d_over)
                begin
                    if (sts.found)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DSEL_FREQ;
                        state_next    = ST_FREQ_WAIT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_SC;
                    state_next    = ST_SC_WAIT;
                end
            end
            ST_SC_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_sc = 1'b1;
                    state_next = ST_B_START;
                end
            end
            ST_B_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_B;
                state_next    = ST_B_WAIT;
            end
            ST_B_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_b  = 1'b1;
                    state_next = ST_B_CHECK;
                end
            end
            ST_B_CHECK:
            begin
                // zero generator value: candidate skipped
                if (sts.b_zero)
                begin
                    cmd.step_d = 1'b1;
                    state_next = ST_CHECK;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_A;
                    state_next    = ST_A_WAIT;
                end
            end
            ST_A_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_a  = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                cmd.step_d = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FREQ_WAIT:
            begin
                cmd.div_sel = DSEL_FREQ;
                if (sts.div_done)
                begin
                    cmd.cap_freq = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.res_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
